### rtl/onp_pkg.sv
// Package for the octahedral normal pack core.
// Holds the per-beat status struct shared by the divider cell and the top level.
package onp_pkg;

  typedef struct packed {
    logic vld;
    logic zero;
  } lane_ctl_t;

endpackage

### rtl/onp_div_cell.sv
// One restoring-division cell of the octahedral quantizer chain.
// One quotient bit per lane per cycle unless stalled; partial state passes on.
module onp_div_cell
  import onp_pkg::*;
#(
  parameter int NUM_BITS = 41,
  parameter int DEN_BITS = 19,
  parameter int Q_BITS   = 24,
  parameter int STEP     = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  lane_ctl_t           ctl_in,
  input  logic [DEN_BITS-1:0] den_in,
  input  logic [NUM_BITS-1:0] num_u_in,
  input  logic [NUM_BITS-1:0] num_v_in,
  input  logic [Q_BITS-1:0]   q_u_in,
  input  logic [Q_BITS-1:0]   q_v_in,
  output lane_ctl_t           ctl_out,
  output logic [DEN_BITS-1:0] den_out,
  output logic [NUM_BITS-1:0] num_u_out,
  output logic [NUM_BITS-1:0] num_v_out,
  output logic [Q_BITS-1:0]   q_u_out,
  output logic [Q_BITS-1:0]   q_v_out
);

  localparam int SH = Q_BITS - 1 - STEP;

  logic [NUM_BITS-1:0] trial;
  logic [NUM_BITS-1:0] nu_next;
  logic [NUM_BITS-1:0] nv_next;
  logic                bu;
  logic                bv;

  assign trial = NUM_BITS'(den_in) << SH;

  always_comb begin
    bu = num_u_in >= trial;
    bv = num_v_in >= trial;
    nu_next = bu ? num_u_in - trial : num_u_in;
    nv_next = bv ? num_v_in - trial : num_v_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else if (adv) begin
      ctl_out <= ctl_in;
    end
    if (adv) begin
      den_out   <= den_in;
      num_u_out <= nu_next;
      num_v_out <= nv_next;
      q_u_out   <= q_u_in | (Q_BITS'(bu) << SH);
      q_v_out   <= q_v_in | (Q_BITS'(bv) << SH);
    end
  end

endmodule

### rtl/octahedral_normal_pack_core.sv
// Top level of the octahedral normal pack core.
// Uses onp_pkg and a chain of onp_div_cell instances.
//
// Usage: one normal (normal_x/y/z, signed) enters on the in_valid/in_ready
// channel; one beat leaves on out_valid/out_ready carrying packed_code
// (U from bit CODE_BITS up, V below) and zero_vector.
// The front stage forms L = |x|+|y|+|z|, 2L and the two folded numerators;
// the next stage multiplies each numerator by 2^CODE_BITS-1. A row of
// CODE_BITS division cells, unless stalled, resolves one quotient bit per
// cycle for both lanes. A beat passes the front stage, the next stage and
// each cell in turn. Throughput: one beat per cycle unless stalled; the
// whole chain advances together. A stalled receiver freezes the chain;
// in_ready then drops only when the output register is full and blocked.
// Reset clears all valid flags; no output beat is shown until new input.
module octahedral_normal_pack_core
  import onp_pkg::*;
#(
  parameter int COMPONENT_BITS = 16,
  parameter int CODE_BITS      = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] normal_x,
  input  logic [COMPONENT_BITS-1:0] normal_y,
  input  logic [COMPONENT_BITS-1:0] normal_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [31:0]               packed_code,
  output logic                      zero_vector
);

  localparam int LB = COMPONENT_BITS + 2;
  localparam int DB = LB + 1;
  localparam int NB = LB + 1 + CODE_BITS;

  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  logic signed [LB-1:0] sx, sy, sz;
  logic [LB-1:0] ax, ay, az, l, nu_a, nv_a, nu, nv;
  always_comb begin
    sx = LB'($signed(normal_x));
    sy = LB'($signed(normal_y));
    sz = LB'($signed(normal_z));
    ax = sx[LB-1] ? LB'(-sx) : LB'(sx);
    ay = sy[LB-1] ? LB'(-sy) : LB'(sy);
    az = sz[LB-1] ? LB'(-sz) : LB'(sz);
    l  = ax + ay + az;
    if (!sz[LB-1]) begin
      nu_a = l + LB'(sx);
      nv_a = l + LB'(sy);
    end else begin
      nu_a = sx[LB-1] ? ay : LB'(l + l - ay);
      nv_a = sy[LB-1] ? ax : LB'(l + l - ax);
    end
    nu = nu_a;
    nv = nv_a;
  end

  lane_ctl_t         c0;
  logic [DB-1:0]     d0;
  logic [LB:0]       a0u, a0v;
  always_ff @(posedge clk) begin
    if (rst) begin
      c0 <= '0;
    end else if (adv) begin
      c0.vld  <= in_valid;
      c0.zero <= l == '0;
    end
    if (adv) begin
      d0  <= {l, 1'b0};
      a0u <= {1'b0, nu};
      a0v <= {1'b0, nv};
    end
  end

  lane_ctl_t         c1;
  logic [DB-1:0]     d1;
  logic [NB-1:0]     n1u, n1v;
  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
    end else if (adv) begin
      c1 <= c0;
    end
    if (adv) begin
      d1  <= d0;
      n1u <= (NB'(a0u) << CODE_BITS) - NB'(a0u);
      n1v <= (NB'(a0v) << CODE_BITS) - NB'(a0v);
    end
  end

  lane_ctl_t             cc [CODE_BITS+1];
  logic [DB-1:0]         dc [CODE_BITS+1];
  logic [NB-1:0]         nc_u [CODE_BITS+1];
  logic [NB-1:0]         nc_v [CODE_BITS+1];
  logic [CODE_BITS-1:0]  qc_u [CODE_BITS+1];
  logic [CODE_BITS-1:0]  qc_v [CODE_BITS+1];

  assign cc[0]   = c1;
  assign dc[0]   = d1;
  assign nc_u[0] = n1u;
  assign nc_v[0] = n1v;
  assign qc_u[0] = '0;
  assign qc_v[0] = '0;

  for (genvar i = 0; i < CODE_BITS; i++) begin : g_cell
    onp_div_cell #(
      .NUM_BITS(NB), .DEN_BITS(DB), .Q_BITS(CODE_BITS), .STEP(i)
    ) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .ctl_in(cc[i]), .den_in(dc[i]),
      .num_u_in(nc_u[i]), .num_v_in(nc_v[i]),
      .q_u_in(qc_u[i]), .q_v_in(qc_v[i]),
      .ctl_out(cc[i+1]), .den_out(dc[i+1]),
      .num_u_out(nc_u[i+1]), .num_v_out(nc_v[i+1]),
      .q_u_out(qc_u[i+1]), .q_v_out(qc_v[i+1])
    );
  end

  logic [2*CODE_BITS-1:0] code_w;
  assign code_w = cc[CODE_BITS].zero ? '0 : {qc_u[CODE_BITS], qc_v[CODE_BITS]};
  assign out_valid   = cc[CODE_BITS].vld;
  assign zero_vector = cc[CODE_BITS].zero;
  assign packed_code = 32'(code_w);

endmodule
